@@ src/chc_pkg.sv @@
// Shared types and constants of the Chaikin curve refiner.
// Used by chc_front, chc_stage, chc_back and the top level; depends on nothing.
`default_nettype none

package chc_pkg;

  localparam int unsigned MAX_PASSES_DEF = 4;
  localparam int unsigned COORD_BITS_DEF = 24;

  // Fixed register widths.
  localparam int unsigned PASS_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  localparam logic [PASS_W-1:0] PASS_RESET = 3'd4;

  // Input queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PASS_COUNT = 2'd0,
    CFG_OPEN_END   = 2'd1
  } cfg_reg_e;

  // Settled configuration handed from the front to the back.
  typedef struct packed {
    logic [PASS_W-1:0] passes;
    logic              open_end;
  } chc_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR_Q,
    ST_PAIR_R,
    ST_CLOSE_Q,
    ST_CLOSE_R
  } stage_state_e;

endpackage

`default_nettype wire

@@ src/chc_front.sv @@
// Front end: configuration registers, input acceptance and the point queue.
// Depends on chc_pkg.
`default_nettype none

module chc_front import chc_pkg::*; #(
  parameter int unsigned MAX_PASSES = MAX_PASSES_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0][COORD_BITS-1:0]     in_pt_i,
  input  logic                           in_end_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  output chc_cfg_t                       cfg_o,
  output logic                           head_valid_o,
  output logic [2:0][COORD_BITS-1:0]     head_pt_o,
  output logic                           head_end_o,
  input  logic                           pop_i
);

  logic [PASS_W-1:0] pass_count_q;
  logic              open_end_q;

  logic [2:0][COORD_BITS-1:0] q_pt  [QUEUE_DEPTH];
  logic                       q_end [QUEUE_DEPTH];
  logic [QPTR_W-1:0]          wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]          count_q;
  logic                       push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_count_q <= PASS_RESET;
      open_end_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PASS_COUNT: pass_count_q <= cfg_data_i;
        CFG_OPEN_END:   open_end_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Counts above the number of built stages saturate.
  always_comb begin
    cfg_o.open_end = open_end_q;
    if (pass_count_q > PASS_W'(MAX_PASSES)) begin
      cfg_o.passes = PASS_W'(MAX_PASSES);
    end else begin
      cfg_o.passes = pass_count_q;
    end
  end

  assign in_stall_o   = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign head_pt_o    = q_pt[rd_ptr_q];
  assign head_end_o   = q_end[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_pt[wr_ptr_q]  <= in_pt_i;
      q_end[wr_ptr_q] <= in_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("point queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("point queue popped while empty");

endmodule

`default_nettype wire

@@ src/chc_stage.sv @@
// One corner-cutting pass: keeps the first and previous point of the curve and
// emits the cut pair for each new point plus the closing pair. Depends on chc_pkg.
`default_nettype none

module chc_stage import chc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       open_end_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0][COORD_BITS-1:0] in_pt_i,
  input  logic                       in_end_i,
  input  logic                       in_tag_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0][COORD_BITS-1:0] out_pt_o,
  output logic                       out_end_o,
  output logic                       out_tag_o
);

  localparam int unsigned SW = COORD_BITS + 2;

  stage_state_e state_q, state_d, start_state;

  logic                       started_q;
  logic [2:0][COORD_BITS-1:0] prev_q, first_q, a_q, p_q, c_q;
  logic                       end_q, tag_q;
  logic                       out_valid_q, out_end_q, out_tag_q;
  logic [2:0][COORD_BITS-1:0] out_pt_q;

  logic                       emit, last_step, in_fire, pair_step, odd_step;
  logic [2:0][COORD_BITS-1:0] u_pt, v_pt, x_pt, y_pt, cut_pt;
  logic [2:0][SW-1:0]         x_ext, y_ext, sum;

  assign last_step  = (state_q == ST_PAIR_R && !end_q) || (state_q == ST_CLOSE_R);
  assign emit       = (state_q != ST_IDLE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == ST_IDLE) || (last_step && emit));
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    if (started_q) begin
      start_state = ST_PAIR_Q;
    end else if (in_end_i) begin
      start_state = ST_CLOSE_Q;
    end else begin
      start_state = ST_IDLE;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    if (emit) begin
      unique case (state_q)
        ST_PAIR_Q:  state_d = ST_PAIR_R;
        ST_PAIR_R:  state_d = end_q ? ST_CLOSE_Q : ST_IDLE;
        ST_CLOSE_Q: state_d = ST_CLOSE_R;
        ST_CLOSE_R: state_d = ST_IDLE;
        default:    state_d = ST_IDLE;
      endcase
    end
    if (in_fire) begin
      state_d = start_state;
    end
  end

  // Outputs: the pair (u, v) gives Q = (3u+v)/4 on even steps and R = (u+3v)/4 on odd ones.
  always_comb begin
    pair_step = (state_q == ST_PAIR_Q) || (state_q == ST_PAIR_R);
    odd_step  = (state_q == ST_PAIR_R) || (state_q == ST_CLOSE_R);
    for (int k = 0; k < 3; k++) begin
      u_pt[k]   = pair_step ? a_q[k] : p_q[k];
      v_pt[k]   = pair_step ? p_q[k] : c_q[k];
      x_pt[k]   = odd_step ? v_pt[k] : u_pt[k];
      y_pt[k]   = odd_step ? u_pt[k] : v_pt[k];
      x_ext[k]  = {{2{x_pt[k][COORD_BITS-1]}}, x_pt[k]};
      y_ext[k]  = {{2{y_pt[k][COORD_BITS-1]}}, y_pt[k]};
      sum[k]    = (x_ext[k] << 1) + x_ext[k] + y_ext[k];
      cut_pt[k] = sum[k][SW-1:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_i) begin
        started_q <= 1'b0;
      end else if (in_fire) begin
        started_q <= !in_end_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q    <= prev_q;
      p_q    <= in_pt_i;
      c_q    <= (open_end_i || !started_q) ? in_pt_i : first_q;
      end_q  <= in_end_i;
      tag_q  <= in_tag_i;
      prev_q <= in_pt_i;
      if (!started_q) begin
        first_q <= in_pt_i;
      end
    end
    if (emit) begin
      out_pt_q  <= cut_pt;
      out_end_q <= (state_q == ST_CLOSE_R);
      out_tag_q <= last_step && tag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pt_o    = out_pt_q;
  assign out_end_o   = out_end_q;
  assign out_tag_o   = out_tag_q;

  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q != ST_IDLE) |-> (last_step && emit))
    else $error("stage took a point before finishing the previous one");

  a_close_not_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLOSE_Q || state_q == ST_CLOSE_R) |-> !started_q)
    else $error("stage still marked started while closing a curve");

  a_close_flags_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && state_q == ST_CLOSE_R) |=> (out_valid_q && out_end_q))
    else $error("closing point not flagged as curve end");

endmodule

`default_nettype wire

@@ src/chc_back.sv @@
// Back end: the cascade of refinement stages and the selection of the active tap.
// Depends on chc_pkg and chc_stage.
`default_nettype none

module chc_back import chc_pkg::*; #(
  parameter int unsigned MAX_PASSES = MAX_PASSES_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  chc_cfg_t                   cfg_i,
  input  logic                       head_valid_i,
  input  logic [2:0][COORD_BITS-1:0] head_pt_i,
  input  logic                       head_end_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0][COORD_BITS-1:0] out_pt_o,
  output logic                       out_end_o,
  output logic                       out_last_o
);

  logic [MAX_PASSES-1:0]      st_in_valid, st_in_stall, st_in_end, st_in_tag;
  logic [MAX_PASSES-1:0]      st_out_valid, st_out_stall, st_out_end, st_out_tag;
  logic [MAX_PASSES-1:0]      st_clr;
  logic [2:0][COORD_BITS-1:0] st_in_pt  [MAX_PASSES];
  logic [2:0][COORD_BITS-1:0] st_out_pt [MAX_PASSES];
  logic                       bypass;

  assign bypass = (cfg_i.passes == '0);

  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign st_in_valid[s] = head_valid_i && !bypass;
      assign st_in_pt[s]    = head_pt_i;
      assign st_in_end[s]   = head_end_i;
      assign st_in_tag[s]   = 1'b1;
    end else begin : g_chain
      assign st_in_valid[s] = st_out_valid[s-1] && (cfg_i.passes > PASS_W'(s));
      assign st_in_pt[s]    = st_out_pt[s-1];
      assign st_in_end[s]   = st_out_end[s-1];
      assign st_in_tag[s]   = st_out_tag[s-1];
    end

    if (s == MAX_PASSES - 1) begin : g_tail
      assign st_out_stall[s] = out_stall_i;
    end else begin : g_mid
      assign st_out_stall[s] = (cfg_i.passes == PASS_W'(s + 1)) ? out_stall_i
                                                                 : st_in_stall[s+1];
    end

    // Unused stages forget their curve each time a word leaves the queue.
    assign st_clr[s] = pop_o && (cfg_i.passes <= PASS_W'(s));

    chc_stage #(
      .COORD_BITS (COORD_BITS)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clr_i       (st_clr[s]),
      .open_end_i  (cfg_i.open_end),
      .in_valid_i  (st_in_valid[s]),
      .in_stall_o  (st_in_stall[s]),
      .in_pt_i     (st_in_pt[s]),
      .in_end_i    (st_in_end[s]),
      .in_tag_i    (st_in_tag[s]),
      .out_valid_o (st_out_valid[s]),
      .out_stall_i (st_out_stall[s]),
      .out_pt_o    (st_out_pt[s]),
      .out_end_o   (st_out_end[s]),
      .out_tag_o   (st_out_tag[s])
    );
  end

  assign pop_o = head_valid_i && (bypass ? !out_stall_i : !st_in_stall[0]);

  // With no passes the queue head goes straight out as a single result.
  always_comb begin
    out_valid_o = bypass && head_valid_i;
    out_pt_o    = head_pt_i;
    out_end_o   = head_end_i;
    out_last_o  = 1'b1;
    for (int s = 0; s < MAX_PASSES; s++) begin
      if (cfg_i.passes == PASS_W'(s + 1)) begin
        out_valid_o = st_out_valid[s];
        out_pt_o    = st_out_pt[s];
        out_end_o   = st_out_end[s];
        out_last_o  = st_out_tag[s];
      end
    end
  end

endmodule

`default_nettype wire

@@ src/chaikin_curve_subdivision.sv @@
// Chaikin corner-cutting curve refiner, top level.
// Depends on chc_pkg, chc_front, chc_back (and chc_stage below it).
//
// Control points enter on the input channel (in_valid_i / in_stall_o) with
// curve_end_i set on the last point of each curve. Refined points leave on the
// output channel (out_valid_o / out_stall_i); run_last_o marks the final result
// caused by an input word and curve_done_o the last refined point of a curve.
// A word moves when valid is high and stall is low. The configuration channel
// (cfg_valid_i / cfg_ready_o) writes pass_count at index 0 and open_end at
// index 1; it is always ready. The user must write it only while the block is
// idle; the block does not enforce this. Points first go into a four-entry
// queue, then through one cut stage per pass. Each stage emits one point per
// cycle unless its receiver stalls, so at n passes an input word yields about
// 2^n refined points (16 at four passes); the last stage's single output port
// sets that rate. With the cascade idle, a word is registered in the queue and
// then in each stage's state and output registers. Reset sets four passes and
// closed curves, empties the queue and forgets any partly seen curve. When the
// receiver stalls, the last stage holds its word, the earlier stages and the
// queue fill up, and then in_stall_o rises.
`default_nettype none

module chaikin_curve_subdivision import chc_pkg::*; #(
  parameter int unsigned MAX_PASSES = MAX_PASSES_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] pz_i,
  input  logic                         curve_end_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] qx_o,
  output logic signed [COORD_BITS-1:0] qy_o,
  output logic signed [COORD_BITS-1:0] qz_o,
  output logic                         run_last_o,
  output logic                         curve_done_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  chc_cfg_t                   cfg;
  logic [2:0][COORD_BITS-1:0] in_pt, head_pt, out_pt;
  logic                       head_valid, head_end, pop;

  assign in_pt[0] = px_i;
  assign in_pt[1] = py_i;
  assign in_pt[2] = pz_i;

  chc_front #(
    .MAX_PASSES (MAX_PASSES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_pt_i      (in_pt),
    .in_end_i     (curve_end_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_o        (cfg),
    .head_valid_o (head_valid),
    .head_pt_o    (head_pt),
    .head_end_o   (head_end),
    .pop_i        (pop)
  );

  chc_back #(
    .MAX_PASSES (MAX_PASSES),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_pt_i    (head_pt),
    .head_end_i   (head_end),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_pt_o     (out_pt),
    .out_end_o    (curve_done_o),
    .out_last_o   (run_last_o)
  );

  assign qx_o = out_pt[0];
  assign qy_o = out_pt[1];
  assign qz_o = out_pt[2];

endmodule

`default_nettype wire
